// ===== rtl/frame_slot_pool_drop_oldest_defines.svh =====
// Assertion macros for the frame slot pool. Each expects clk and rst_n in scope.
`ifndef FRAME_SLOT_POOL_DROP_OLDEST_DEFINES_SVH
`define FRAME_SLOT_POOL_DROP_OLDEST_DEFINES_SVH
`ifndef SYNTH
`define FSPDO_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fspdo: same-cycle check failed");
`define FSPDO_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fspdo: next-cycle check failed");
`else
`define FSPDO_ASSERT_IMPLY(name, ante, cons)
`define FSPDO_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/fspdo_pkg.sv =====
`default_nettype none
package fspdo_pkg;

    localparam int POOL_DEPTH_DEF  = 16;
    localparam int MAX_FRAME_BYTES = 4096;
    // granted_slot is 4 bits wide, so at most 16 slots can ever be filled
    localparam int SLOT_LIMIT      = 16;
    localparam int CAP_W           = 5;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd1;

    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_POP     = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_FLUSH   = 2'd3;

    localparam logic [2:0] RS_OK       = 3'd0;
    localparam logic [2:0] RS_EMPTY    = 3'd1;
    localparam logic [2:0] RS_NO_SLOT  = 3'd2;
    localparam logic [2:0] RS_TOO_LONG = 3'd3;
    localparam logic [2:0] RS_IGNORED  = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] frame_length;
        logic [7:0]  slot_index;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  granted_slot;
        logic [15:0] granted_length;
        logic        evicted;
        logic [31:0] drop_total;
    } rsp_item_t;

endpackage
`default_nettype wire

// ===== rtl/frame_slot_pool_drop_oldest.sv =====
`default_nettype none
// Frame slot pool with a drop-oldest ready queue. Each request (push, pop, release,
// flush) gives exactly one response. A request goes through accept, execute and
// response load. A push that evicts the oldest ready frame adds S_EVICT1 when no
// slot is free and S_EVICT2 when a lowered capacity leaves the queue over its limit
// and an entry is dropped. A successful pop adds S_POP1 and S_POP2, since the ready
// ring and the slot length store are synchronous memories with a registered read
// and a pop reads them in series. A new request is taken while the previous response
// still waits on rsp. Free/used state of the slots sits in flops so the lowest free
// slot below the capacity is found combinationally. Configuration writes are accepted
// in any cycle and must only be issued while no request is in flight.
`include "frame_slot_pool_drop_oldest_defines.svh"
module frame_slot_pool_drop_oldest #(
    parameter int POOL_DEPTH = fspdo_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire fspdo_pkg::req_item_t            req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output fspdo_pkg::rsp_item_t                 rsp,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fspdo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fspdo_pkg::CAP_W-1:0]     cfg_data
);

    localparam int NSLOT  = (POOL_DEPTH < fspdo_pkg::SLOT_LIMIT) ?
                            POOL_DEPTH : fspdo_pkg::SLOT_LIMIT;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int RING_W = $clog2(POOL_DEPTH);
    localparam int CAP_W  = fspdo_pkg::CAP_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_EVICT1 = 3'd2;
    localparam logic [2:0] S_EVICT2 = 3'd3;
    localparam logic [2:0] S_POP1   = 3'd4;
    localparam logic [2:0] S_POP2   = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]             state_reg, state_next;
    fspdo_pkg::req_item_t   req_reg, req_next;
    logic [NSLOT-1:0]       busy_reg, busy_next;
    logic [RING_W-1:0]      head_reg, head_next;
    logic [RING_W-1:0]      tail_reg, tail_next;
    logic [CAP_W-1:0]       count_reg, count_next;
    logic [31:0]            drop_reg, drop_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic                   enable_reg, enable_next;
    logic [2:0]             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [15:0]            res_len_reg, res_len_next;
    logic                   res_ev_reg, res_ev_next;
    fspdo_pkg::rsp_item_t   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [SLOT_W-1:0]      ring_mem [POOL_DEPTH];
    logic [SLOT_W-1:0]      ring_rdata_reg;
    logic                   ring_we;
    logic [SLOT_W-1:0]      ring_wdata;
    logic [15:0]            len_mem [NSLOT];
    logic [15:0]            len_rdata_reg;
    logic                   len_we;
    logic [SLOT_W-1:0]      len_waddr;

    logic [CAP_W-1:0]       cap_eff;
    logic                   queue_full;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_idx;
    logic                   too_long;
    logic [RING_W-1:0]      head_inc;
    logic [RING_W-1:0]      tail_inc;
    logic                   rsp_load;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_load  = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);

    // Memories: the ring is always read at the head, the length store at the ring output.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[tail_reg] <= ring_wdata;
        end
        ring_rdata_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= req_reg.frame_length;
        end
        len_rdata_reg <= len_mem[ring_rdata_reg];
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (32'(cap_reg) > POOL_DEPTH)
        begin
            cap_eff = CAP_W'(POOL_DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign queue_full = (count_reg >= cap_eff);
    assign too_long   = (req_reg.frame_length > 16'(fspdo_pkg::MAX_FRAME_BYTES));
    assign head_inc   = (head_reg == RING_W'(POOL_DEPTH - 1)) ? '0 : head_reg + RING_W'(1);
    assign tail_inc   = (tail_reg == RING_W'(POOL_DEPTH - 1)) ? '0 : tail_reg + RING_W'(1);

    // Lowest free slot below the effective capacity.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i] && (i < 32'(cap_eff)))
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        busy_next       = busy_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        cap_next        = cap_reg;
        enable_next     = enable_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_len_next    = res_len_reg;
        res_ev_next     = res_ev_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        ring_we         = 1'b0;
        ring_wdata      = res_slot_reg;
        len_we          = 1'b0;
        len_waddr       = res_slot_reg;

        if (cfg_valid)
        begin
            if (cfg_index == fspdo_pkg::CFG_CAPACITY)
            begin
                cap_next = cfg_data;
            end
            else if (cfg_index == fspdo_pkg::CFG_ENABLE)
            begin
                enable_next = cfg_data[0];
            end
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    res_status_next = fspdo_pkg::RS_OK;
                    res_slot_next   = '0;
                    res_len_next    = '0;
                    res_ev_next     = 1'b0;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                unique case (req_reg.req_type)
                    fspdo_pkg::REQ_PUSH:
                    begin
                        if (!enable_reg)
                        begin
                            res_status_next = fspdo_pkg::RS_IGNORED;
                        end
                        else if (!free_found && queue_full)
                        begin
                            // evict the oldest ready frame and reuse its slot
                            head_next   = head_inc;
                            count_next  = count_reg - CAP_W'(1);
                            drop_next   = drop_reg + 32'd1;
                            res_ev_next = 1'b1;
                            state_next  = S_EVICT1;
                        end
                        else if (!free_found)
                        begin
                            drop_next       = drop_reg + 32'd1;
                            res_status_next = fspdo_pkg::RS_NO_SLOT;
                        end
                        else if (too_long)
                        begin
                            drop_next       = drop_reg + 32'd1;
                            res_status_next = fspdo_pkg::RS_TOO_LONG;
                        end
                        else
                        begin
                            len_we              = 1'b1;
                            len_waddr           = free_idx;
                            busy_next[free_idx] = 1'b1;
                            res_slot_next       = free_idx;
                            res_len_next        = req_reg.frame_length;
                            if (queue_full)
                            begin
                                // free slot but queue at limit: drop the oldest entry
                                head_next   = head_inc;
                                count_next  = count_reg - CAP_W'(1);
                                drop_next   = drop_reg + 32'd1;
                                res_ev_next = 1'b1;
                                state_next  = S_EVICT2;
                            end
                            else
                            begin
                                ring_we    = 1'b1;
                                ring_wdata = free_idx;
                                tail_next  = tail_inc;
                                count_next = count_reg + CAP_W'(1);
                            end
                        end
                    end
                    fspdo_pkg::REQ_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = fspdo_pkg::RS_EMPTY;
                        end
                        else
                        begin
                            head_next  = head_inc;
                            count_next = count_reg - CAP_W'(1);
                            state_next = S_POP1;
                        end
                    end
                    fspdo_pkg::REQ_RELEASE:
                    begin
                        if (32'(req_reg.slot_index) < POOL_DEPTH)
                        begin
                            if (32'(req_reg.slot_index) < NSLOT)
                            begin
                                busy_next[req_reg.slot_index[SLOT_W-1:0]] = 1'b0;
                            end
                        end
                        else
                        begin
                            res_status_next = fspdo_pkg::RS_IGNORED;
                        end
                    end
                    fspdo_pkg::REQ_FLUSH:
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                        busy_next  = '0;
                    end
                    default:
                    begin
                        res_status_next = fspdo_pkg::RS_IGNORED;
                    end
                endcase
            end
            S_EVICT1:
            begin
                state_next = S_OUT;
                if (too_long)
                begin
                    busy_next[ring_rdata_reg] = 1'b0;
                    drop_next                 = drop_reg + 32'd1;
                    res_status_next           = fspdo_pkg::RS_TOO_LONG;
                end
                else
                begin
                    busy_next[ring_rdata_reg] = 1'b1;
                    len_we        = 1'b1;
                    len_waddr     = ring_rdata_reg;
                    res_slot_next = ring_rdata_reg;
                    res_len_next  = req_reg.frame_length;
                    if (queue_full)
                    begin
                        // queue still over a lowered limit: drop the next oldest entry too
                        head_next  = head_inc;
                        count_next = count_reg - CAP_W'(1);
                        drop_next  = drop_reg + 32'd1;
                        state_next = S_EVICT2;
                    end
                    else
                    begin
                        ring_we    = 1'b1;
                        ring_wdata = ring_rdata_reg;
                        tail_next  = tail_inc;
                        count_next = count_reg + CAP_W'(1);
                    end
                end
            end
            S_EVICT2:
            begin
                // the dropped entry may point at the new slot; its free mark wins
                busy_next[ring_rdata_reg] = 1'b0;
                ring_we    = 1'b1;
                ring_wdata = res_slot_reg;
                tail_next  = tail_inc;
                count_next = count_reg + CAP_W'(1);
                state_next = S_OUT;
            end
            S_POP1:
            begin
                busy_next[ring_rdata_reg] = 1'b1;
                res_slot_next             = ring_rdata_reg;
                state_next                = S_POP2;
            end
            S_POP2:
            begin
                res_len_next = len_rdata_reg;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_load)
                begin
                    rsp_next.status         = res_status_reg;
                    rsp_next.granted_slot   = 4'(res_slot_reg);
                    rsp_next.granted_length = res_len_reg;
                    rsp_next.evicted        = res_ev_reg;
                    rsp_next.drop_total     = drop_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            drop_reg      <= '0;
            cap_reg       <= fspdo_pkg::CAP_RESET;
            enable_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            cap_reg       <= cap_next;
            enable_reg    <= enable_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_len_reg    <= res_len_next;
        res_ev_reg     <= res_ev_next;
        rsp_reg        <= rsp_next;
    end

    `FSPDO_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CAP_W'(NSLOT))
    `FSPDO_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_reg == S_EXEC)
    `FSPDO_ASSERT_IMPLY(a_rsp_from_out, $rose(rsp_valid_reg), $past(state_reg) == S_OUT)
    `FSPDO_ASSERT_IMPLY(a_pop_nonempty, state_reg == S_POP1, $past(count_reg) != '0)

endmodule
`default_nettype wire
